### rtl/sise_pkg.sv
// Shared types and constants for the sorted interval set engine.
`timescale 1ns / 1ps

package sise_pkg;

  localparam int SET_CAPACITY = 16;
  localparam int MAX_RESULTS  = 32;
  localparam int DATA_W       = 32;

  typedef enum logic [2:0] {
    ACT_CLEAR = 3'd0,
    ACT_APP_A = 3'd1,
    ACT_APP_B = 3'd2,
    ACT_EXT_A = 3'd3,
    ACT_EXT_B = 3'd4,
    ACT_UNION = 3'd5,
    ACT_MEET  = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MEET_A,
    ST_MEET_B,
    ST_UNION
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } entry_t;

  typedef struct packed {
    logic   en;
    logic   set_b;
    entry_t data;
  } wr_req_t;

endpackage

### rtl/sise_store.sv
// Interval storage for sets A and B: one write port steered by set_b, one registered read per set.
`timescale 1ns / 1ps

module sise_store #(
  parameter int CAPACITY = sise_pkg::SET_CAPACITY,
  parameter int ADDR_W   = $clog2(sise_pkg::SET_CAPACITY)
) (
  input  logic               clk,
  input  sise_pkg::wr_req_t  wr,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [ADDR_W-1:0]  rd_addr_a,
  input  logic [ADDR_W-1:0]  rd_addr_b,
  output sise_pkg::entry_t   rd_a,
  output sise_pkg::entry_t   rd_b
);

  sise_pkg::entry_t mem_a [CAPACITY];
  sise_pkg::entry_t mem_b [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en && !wr.set_b) begin
      mem_a[wr_addr] <= wr.data;
    end
    rd_a <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.set_b) begin
      mem_b[wr_addr] <= wr.data;
    end
    rd_b <= mem_b[rd_addr_b];
  end

endmodule

### rtl/sorted_interval_set_engine.sv
// Top level of the sorted interval set engine: sequencer, pointers and result register.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Clear, append, extend and the
// unused action take the item, then run one execute step that reads the last entry of the
// target set and may rewrite it or add one; their single result appears on the cycle after.
// Intersect walks with one step per pointer advance or turn to the other set, and gives its
// result in its first walk step when a set is empty. Union runs one merge step per stored
// interval plus one closing step, and emits a result on each step that closes a merged
// interval, stopping once MAX_RESULTS results are out. The pace is set by the
// one read port per set in the interval store, one entry of each set per cycle. Results
// are shown for one cycle under done and cannot be held off; a new item may be taken in
// the cycle that shows the last result. Stores need no clearing pass after reset.
module sorted_interval_set_engine #(
  parameter int SET_CAPACITY = sise_pkg::SET_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  action,
  input  logic [sise_pkg::DATA_W-1:0] start_value,
  input  logic [sise_pkg::DATA_W-1:0] end_value,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [sise_pkg::DATA_W-1:0] union_start,
  output logic [sise_pkg::DATA_W-1:0] union_end,
  output logic                        union_valid,
  output logic                        sets_meet,
  output logic                        last_result
);

  localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CW = $clog2(SET_CAPACITY + 1);
  localparam int KW = $clog2(sise_pkg::MAX_RESULTS);

  sise_pkg::state_t  state, state_next;
  sise_pkg::action_t act, act_next;
  logic [sise_pkg::DATA_W-1:0] s_in, s_in_next, e_in, e_in_next;
  logic [CW-1:0] a_count, a_count_next, b_count, b_count_next;
  logic [CW-1:0] ai, ai_next, bi, bi_next;
  logic [KW-1:0] k, k_next;
  sise_pkg::entry_t cur, cur_next;
  logic have_cur, have_cur_next;

  logic                        emit;
  logic [1:0]                  emit_status;
  logic [sise_pkg::DATA_W-1:0] emit_us, emit_ue;
  logic                        emit_uv, emit_meet, emit_last;

  sise_pkg::wr_req_t wr;
  logic [IW-1:0]     wr_addr;
  sise_pkg::entry_t  rd_a, rd_b;

  sise_pkg::entry_t last_ent, pick;
  logic [CW-1:0]    cnt, li_ptr;
  logic             tgt_b, a_left, b_left, take_a;

  sise_store #(
    .CAPACITY (SET_CAPACITY),
    .ADDR_W   (IW)
  ) u_store (
    .clk       (clk),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .rd_addr_a (ai_next[IW-1:0]),
    .rd_addr_b (bi_next[IW-1:0]),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  assign busy = (state != sise_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sise_pkg::ST_IDLE;
      a_count  <= '0;
      b_count  <= '0;
      done     <= 1'b0;
      have_cur <= 1'b0;
      k        <= '0;
    end else begin
      state    <= state_next;
      a_count  <= a_count_next;
      b_count  <= b_count_next;
      done     <= emit;
      have_cur <= have_cur_next;
      k        <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    act         <= act_next;
    s_in        <= s_in_next;
    e_in        <= e_in_next;
    ai          <= ai_next;
    bi          <= bi_next;
    cur         <= cur_next;
    status      <= emit_status;
    union_start <= emit_us;
    union_end   <= emit_ue;
    union_valid <= emit_uv;
    sets_meet   <= emit_meet;
    last_result <= emit_last;
  end

  always_comb begin
    state_next    = state;
    act_next      = act;
    s_in_next     = s_in;
    e_in_next     = e_in;
    a_count_next  = a_count;
    b_count_next  = b_count;
    ai_next       = ai;
    bi_next       = bi;
    k_next        = k;
    cur_next      = cur;
    have_cur_next = have_cur;
    emit          = 1'b0;
    emit_status   = sise_pkg::STATUS_OK;
    emit_us       = '0;
    emit_ue       = '0;
    emit_uv       = 1'b0;
    emit_meet     = 1'b0;
    emit_last     = 1'b0;
    wr            = '0;
    wr_addr       = '0;

    tgt_b    = (act == sise_pkg::ACT_APP_B) || (act == sise_pkg::ACT_EXT_B);
    last_ent = tgt_b ? rd_b : rd_a;
    cnt      = tgt_b ? b_count : a_count;
    li_ptr   = tgt_b ? bi : ai;
    a_left   = (ai < a_count);
    b_left   = (bi < b_count);
    take_a   = a_left && (!b_left || (rd_a.lo < rd_b.lo));
    pick     = take_a ? rd_a : rd_b;

    unique case (state)
      sise_pkg::ST_IDLE: begin
        if (start) begin
          act_next  = sise_pkg::action_t'(action);
          s_in_next = start_value;
          e_in_next = end_value;
          if (action == sise_pkg::ACT_UNION || action == sise_pkg::ACT_MEET) begin
            ai_next       = '0;
            bi_next       = '0;
            k_next        = '0;
            have_cur_next = 1'b0;
            state_next    = (action == sise_pkg::ACT_UNION) ? sise_pkg::ST_UNION
                                                            : sise_pkg::ST_MEET_A;
          end else begin
            ai_next    = CW'(a_count - CW'(1));
            bi_next    = CW'(b_count - CW'(1));
            state_next = sise_pkg::ST_EXEC;
          end
        end
      end

      sise_pkg::ST_EXEC: begin
        wr.set_b = tgt_b;
        case (act)
          sise_pkg::ACT_CLEAR: begin
            a_count_next = '0;
            b_count_next = '0;
          end
          sise_pkg::ACT_APP_A, sise_pkg::ACT_APP_B: begin
            priority if (s_in >= e_in) begin
              emit_status = sise_pkg::STATUS_BAD;
            end else if (cnt != '0 && last_ent.lo > s_in) begin
              emit_status = sise_pkg::STATUS_BAD;
            end else if (cnt != '0 && last_ent.hi >= s_in) begin
              if (last_ent.hi < e_in) begin
                wr.en   = 1'b1;
                wr.data = '{lo: last_ent.lo, hi: e_in};
                wr_addr = li_ptr[IW-1:0];
              end
            end else if (cnt >= CW'(SET_CAPACITY)) begin
              emit_status = sise_pkg::STATUS_FULL;
            end else begin
              wr.en   = 1'b1;
              wr.data = '{lo: s_in, hi: e_in};
              wr_addr = cnt[IW-1:0];
              if (tgt_b) begin
                b_count_next = CW'(b_count + CW'(1));
              end else begin
                a_count_next = CW'(a_count + CW'(1));
              end
            end
          end
          sise_pkg::ACT_EXT_A, sise_pkg::ACT_EXT_B: begin
            priority if (cnt == '0 || last_ent.hi > e_in) begin
              emit_status = sise_pkg::STATUS_BAD;
            end else begin
              wr.en   = 1'b1;
              wr.data = '{lo: last_ent.lo, hi: e_in};
              wr_addr = li_ptr[IW-1:0];
            end
          end
          default: begin
          end
        endcase
        emit       = 1'b1;
        emit_last  = 1'b1;
        state_next = sise_pkg::ST_IDLE;
      end

      sise_pkg::ST_MEET_A: begin
        priority if (a_count == '0 || b_count == '0) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          state_next = sise_pkg::ST_IDLE;
        end else if (rd_a.hi <= rd_b.lo) begin
          if (CW'(ai + CW'(1)) >= a_count) begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            state_next = sise_pkg::ST_IDLE;
          end else begin
            ai_next = CW'(ai + CW'(1));
          end
        end else if (rd_a.lo <= rd_b.hi) begin
          emit       = 1'b1;
          emit_meet  = 1'b1;
          emit_last  = 1'b1;
          state_next = sise_pkg::ST_IDLE;
        end else begin
          state_next = sise_pkg::ST_MEET_B;
        end
      end

      sise_pkg::ST_MEET_B: begin
        priority if (rd_b.hi <= rd_a.lo) begin
          if (CW'(bi + CW'(1)) >= b_count) begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            state_next = sise_pkg::ST_IDLE;
          end else begin
            bi_next = CW'(bi + CW'(1));
          end
        end else if (rd_b.lo <= rd_a.hi) begin
          emit       = 1'b1;
          emit_meet  = 1'b1;
          emit_last  = 1'b1;
          state_next = sise_pkg::ST_IDLE;
        end else begin
          state_next = sise_pkg::ST_MEET_A;
        end
      end

      sise_pkg::ST_UNION: begin
        if (a_left || b_left) begin
          if (take_a) begin
            ai_next = CW'(ai + CW'(1));
          end else begin
            bi_next = CW'(bi + CW'(1));
          end
          if (have_cur && cur.hi >= pick.lo) begin
            if (cur.hi < pick.hi) begin
              cur_next.hi = pick.hi;
            end
          end else begin
            cur_next      = pick;
            have_cur_next = 1'b1;
            if (have_cur) begin
              emit    = 1'b1;
              emit_us = cur.lo;
              emit_ue = cur.hi;
              emit_uv = 1'b1;
              k_next  = KW'(k + KW'(1));
              if (k == KW'(sise_pkg::MAX_RESULTS - 1)) begin
                emit_last  = 1'b1;
                state_next = sise_pkg::ST_IDLE;
              end
            end
          end
        end else begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          emit_uv    = have_cur;
          emit_us    = have_cur ? cur.lo : '0;
          emit_ue    = have_cur ? cur.hi : '0;
          state_next = sise_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = sise_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (a_count <= CW'(SET_CAPACITY)) && (b_count <= CW'(SET_CAPACITY)))
    else $error("set count beyond capacity");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (done && last_result) |-> (state == sise_pkg::ST_IDLE))
    else $error("last result while item still in progress");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) != sise_pkg::ST_IDLE))
    else $error("result without an item at work");

  a_meet_not_union: assert property (@(posedge clk) disable iff (rst)
    (done && sets_meet) |-> (!union_valid && last_result))
    else $error("intersect result mixed with union interval");
`endif

endmodule

### dv/sise_result_checker.sv
// Result checker for the sorted interval set engine: predicts each item and compares results.
`timescale 1ns / 1ps

module sise_result_checker
  import sise_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        action,
  input  logic [DATA_W-1:0] start_value,
  input  logic [DATA_W-1:0] end_value,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic [DATA_W-1:0] union_start,
  input  logic [DATA_W-1:0] union_end,
  input  logic              union_valid,
  input  logic              sets_meet,
  input  logic              last_result,
  output int                errors,
  output int                pending
);

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic              valid;
    logic              meet;
    logic              last;
  } set_result_t;

  // index 0 is set A, index 1 is set B
  logic [DATA_W-1:0] lo_q [2][SET_CAPACITY];
  logic [DATA_W-1:0] hi_q [2][SET_CAPACITY];
  int                held [2];
  set_result_t       expected_results [$];
  set_result_t       want;

  initial errors = 0;

  function automatic void queue_result(status_t st, logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                                       logic valid, logic meet, logic last);
    set_result_t r;
    r.status = st;
    r.lo     = lo;
    r.hi     = hi;
    r.valid  = valid;
    r.meet   = meet;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  function automatic status_t add_interval(int k, logic [DATA_W-1:0] s, logic [DATA_W-1:0] e);
    int li;
    if (s >= e) return STATUS_BAD;
    if (held[k] > 0) begin
      li = held[k] - 1;
      if (lo_q[k][li] > s) return STATUS_BAD;
      // merge into the last interval when it overlaps or touches
      if (hi_q[k][li] >= s) begin
        if (hi_q[k][li] < e) hi_q[k][li] = e;
        return STATUS_OK;
      end
    end
    if (held[k] >= SET_CAPACITY) return STATUS_FULL;
    lo_q[k][held[k]] = s;
    hi_q[k][held[k]] = e;
    held[k]++;
    return STATUS_OK;
  endfunction

  function automatic status_t stretch_end(int k, logic [DATA_W-1:0] e);
    int li;
    if (held[k] == 0) return STATUS_BAD;
    li = held[k] - 1;
    if (hi_q[k][li] > e) return STATUS_BAD;
    hi_q[k][li] = e;
    return STATUS_OK;
  endfunction

  // two-pointer walk; touching intervals do not count as meeting
  function automatic logic sets_touch();
    int   ai;
    int   bi;
    logic phase_b;
    logic meet;
    logic fin;
    ai      = 0;
    bi      = 0;
    phase_b = 1'b0;
    meet    = 1'b0;
    fin     = 1'b0;
    if (held[0] == 0 || held[1] == 0) return 1'b0;
    while (!fin) begin
      if (!phase_b) begin
        if (hi_q[0][ai] <= lo_q[1][bi]) begin
          ai++;
          if (ai >= held[0]) fin = 1'b1;
        end else begin
          meet    = (lo_q[0][ai] <= hi_q[1][bi]);
          fin     = meet;
          phase_b = 1'b1;
        end
      end else begin
        if (hi_q[1][bi] <= lo_q[0][ai]) begin
          bi++;
          if (bi >= held[1]) fin = 1'b1;
        end else begin
          meet    = (lo_q[1][bi] <= hi_q[0][ai]);
          fin     = meet;
          phase_b = 1'b0;
        end
      end
    end
    return meet;
  endfunction

  function automatic void queue_union();
    logic [DATA_W-1:0] m_lo [2*SET_CAPACITY];
    logic [DATA_W-1:0] m_hi [2*SET_CAPACITY];
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] e;
    int                n;
    int                ai;
    int                bi;
    int                total;
    n  = 0;
    ai = 0;
    bi = 0;
    while (ai < held[0] || bi < held[1]) begin
      // equal starts take B first
      if (ai < held[0] && (bi >= held[1] || lo_q[0][ai] < lo_q[1][bi])) begin
        s = lo_q[0][ai];
        e = hi_q[0][ai];
        ai++;
      end else begin
        s = lo_q[1][bi];
        e = hi_q[1][bi];
        bi++;
      end
      if (n > 0 && m_hi[n-1] >= s) begin
        if (m_hi[n-1] < e) m_hi[n-1] = e;
      end else begin
        m_lo[n] = s;
        m_hi[n] = e;
        n++;
      end
    end
    if (n == 0) begin
      queue_result(STATUS_OK, '0, '0, 1'b0, 1'b0, 1'b1);
    end else begin
      total = (n > MAX_RESULTS) ? MAX_RESULTS : n;
      for (int k = 0; k < total; k++)
        queue_result(STATUS_OK, m_lo[k], m_hi[k], 1'b1, 1'b0, k == total - 1);
    end
  endfunction

  function automatic void predict_item(logic [2:0] act, logic [DATA_W-1:0] s,
                                       logic [DATA_W-1:0] e);
    status_t st;
    logic    meet;
    st   = STATUS_OK;
    meet = 1'b0;
    case (act)
      ACT_CLEAR: begin
        held[0] = 0;
        held[1] = 0;
      end
      ACT_APP_A: st = add_interval(0, s, e);
      ACT_APP_B: st = add_interval(1, s, e);
      ACT_EXT_A: st = stretch_end(0, e);
      ACT_EXT_B: st = stretch_end(1, e);
      ACT_MEET:  meet = sets_touch();
      default: ;
    endcase
    if (act == ACT_UNION) queue_union();
    else queue_result(st, '0, '0, 1'b0, meet, 1'b1);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held[0] = 0;
      held[1] = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (union_start !== want.lo) begin
            $error("union_start: expected %h, got %h", want.lo, union_start);
            errors++;
          end
          if (union_end !== want.hi) begin
            $error("union_end: expected %h, got %h", want.hi, union_end);
            errors++;
          end
          if (union_valid !== want.valid) begin
            $error("union_valid: expected %0d, got %0d", want.valid, union_valid);
            errors++;
          end
          if (sets_meet !== want.meet) begin
            $error("sets_meet: expected %0d, got %0d", want.meet, sets_meet);
            errors++;
          end
          if (last_result !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, last_result);
            errors++;
          end
        end
      end
      if (start && !busy) predict_item(action, start_value, end_value);
      pending <= expected_results.size();
    end
  end

endmodule

### dv/tb_sorted_interval_set_engine.sv
// Testbench top for the sorted interval set engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_sorted_interval_set_engine;
  import sise_pkg::*;

  localparam logic [2:0] ACT_UNUSED  = 3'd7;
  localparam int         ITEM_TARGET = 380;
  localparam int         STALL_LIMIT = 4000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [2:0]        action;
  logic [DATA_W-1:0] start_value;
  logic [DATA_W-1:0] end_value;
  logic              done;
  logic [1:0]        status;
  logic [DATA_W-1:0] union_start;
  logic [DATA_W-1:0] union_end;
  logic              union_valid;
  logic              sets_meet;
  logic              last_result;
  int                errors;
  int                pending;
  int                items;
  int                stall_cycles;
  logic [DATA_W-1:0] cs [2];
  logic [DATA_W-1:0] ce [2];

  sorted_interval_set_engine u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .start_value (start_value),
    .end_value   (end_value),
    .done        (done),
    .status      (status),
    .union_start (union_start),
    .union_end   (union_end),
    .union_valid (union_valid),
    .sets_meet   (sets_meet),
    .last_result (last_result)
  );

  sise_result_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .start_value (start_value),
    .end_value   (end_value),
    .done        (done),
    .status      (status),
    .union_start (union_start),
    .union_end   (union_end),
    .union_valid (union_valid),
    .sets_meet   (sets_meet),
    .last_result (last_result),
    .errors      (errors),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[sorted_interval_set_engine] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] sat_add(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[DATA_W] ? '1 : t[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] span();
    return $urandom >> $urandom_range(2, 31);
  endfunction

  task automatic send_item(input logic [2:0] act, input logic [DATA_W-1:0] s,
                           input logic [DATA_W-1:0] e);
    @(negedge clk);
    // no idling in a stretch of the run
    while ((items < 140 || items >= 240) && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    action      <= act;
    start_value <= s;
    end_value   <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    items++;
  endtask

  task automatic append_to(input int k);
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] e;
    int                mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) s = cs[k] + $urandom_range(ce[k] - cs[k], 0);
    else if (mode == 2) s = (cs[k] > cs[1-k]) ? cs[k] : cs[1-k];
    else s = sat_add(ce[k], span());
    e = sat_add(s, span() + 1);
    if ($urandom_range(0, 19) == 0) e = $urandom;
    send_item(k ? ACT_APP_B : ACT_APP_A, s, e);
    if (s >= cs[k] && e > s) begin
      cs[k] = s;
      if (e > ce[k]) ce[k] = e;
    end
  endtask

  task automatic random_op();
    int                r;
    int                k;
    logic [DATA_W-1:0] e;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 1);
    if (r < 76) begin
      append_to(r < 38 ? 0 : 1);
    end else if (r < 86) begin
      e = ($urandom_range(0, 5) == 0) ? $urandom_range(ce[k], 0) : sat_add(ce[k], span());
      send_item(k ? ACT_EXT_B : ACT_EXT_A, $urandom, e);
      if (e > ce[k]) ce[k] = e;
    end else if (r < 92) begin
      send_item(k ? ACT_MEET : ACT_UNION, $urandom, $urandom);
    end else begin
      send_item(3'($urandom_range(0, 7)), $urandom, $urandom);
    end
  endtask

  task automatic run_episode();
    int                kind;
    int                k;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] s;
    kind = $urandom_range(0, 5);
    if ($urandom_range(0, 7) != 0) send_item(ACT_CLEAR, $urandom, $urandom);
    base  = (kind == 0) ? ($urandom >> 8) : ($urandom >> $urandom_range(0, 31));
    cs[0] = base;
    cs[1] = base;
    ce[0] = base;
    ce[1] = base;
    if (kind == 0) begin
      // fill one set past capacity with disjoint intervals
      k = $urandom_range(0, 1);
      repeat ($urandom_range(17, 19)) begin
        s = sat_add(ce[k], $urandom_range(1, 1000));
        ce[k] = sat_add(s, $urandom_range(1, 1000));
        cs[k] = s;
        send_item(k ? ACT_APP_B : ACT_APP_A, s, ce[k]);
      end
    end else begin
      repeat ($urandom_range(3, 20)) random_op();
    end
    send_item(ACT_UNION, $urandom, $urandom);
    send_item(ACT_MEET, $urandom, $urandom);
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    action      = ACT_CLEAR;
    start_value = '0;
    end_value   = '0;
    items       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(ACT_CLEAR, '0, '0);
    send_item(ACT_MEET, '0, '0);
    send_item(ACT_UNION, '0, '0);
    send_item(ACT_EXT_A, '0, 32'd7);
    send_item(ACT_EXT_B, '1, '1);
    send_item(ACT_APP_A, 32'd5, 32'd5);
    send_item(ACT_APP_B, '1, '0);
    send_item(ACT_APP_A, 32'd0, 32'd10);
    send_item(ACT_APP_A, 32'd10, 32'd20);
    send_item(ACT_APP_A, 32'd40, 32'd50);
    send_item(ACT_APP_A, 32'd30, 32'd60);
    send_item(ACT_EXT_A, '0, 32'd45);
    send_item(ACT_EXT_A, '0, 32'd55);
    send_item(ACT_APP_B, 32'd0, 32'd5);
    send_item(ACT_APP_B, 32'd20, 32'd40);
    send_item(ACT_MEET, '0, '0);
    send_item(ACT_APP_B, 32'hFFFF_FFF0, '1);
    send_item(ACT_APP_A, 32'hFFFF_FFFE, '1);
    send_item(ACT_EXT_B, '0, '1);
    send_item(ACT_UNUSED, '1, '1);
    send_item(ACT_UNION, '1, '1);
    send_item(ACT_CLEAR, '1, '1);
    send_item(ACT_APP_A, 32'd100, 32'd200);
    send_item(ACT_APP_B, 32'd200, 32'd300);
    send_item(ACT_MEET, '0, '0);
    send_item(ACT_UNION, '0, '0);

    while (items < ITEM_TARGET) run_episode();

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("[sorted_interval_set_engine] OK");
    end else begin
      $display("[sorted_interval_set_engine] ERROR");
    end
    $finish;
  end

endmodule
